// File: design/rotation_inverse_mapper_unit_macros.svh
// Assertion macros shared by the rotation inverse mapper RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ROTATION_INVERSE_MAPPER_UNIT_MACROS_SVH
`define ROTATION_INVERSE_MAPPER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RIM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotation inverse mapper: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RIM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotation inverse mapper: next-cycle check failed");

`endif

// File: design/rim_pkg.sv
// Package for the rotation inverse mapper: field widths, fixed-point format,
// register indexes and reset values. No dependencies.
package rim_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int MAX_DIM    = 4096;
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int COEF_W     = 16;
    localparam int DELTA_W    = COORD_W + 1;
    localparam int PROD_W     = COEF_W + DELTA_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int POS_W      = SUM_W - FRAC_BITS + 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 2 * COORD_W;
    localparam int OUT_DATA_W = 2 * COORD_W;

    localparam logic [COEF_W-1:0] COS_RESET = COEF_W'(1 << FRAC_BITS);
    localparam logic [COEF_W-1:0] SIN_RESET = '0;
    localparam logic [DIM_W-1:0]  DIM_RESET = DIM_W'(MAX_DIM);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COS   = 3'd0,
        REG_SIN   = 3'd1,
        REG_SRC_W = 3'd2,
        REG_SRC_H = 3'd3,
        REG_DST_W = 3'd4,
        REG_DST_H = 3'd5
    } cfg_reg_t;

endpackage

// File: design/rim_coord.sv
// One output coordinate of the inverse mapping: a registered pair of products,
// then sum, ceiling shift and source center. Depends on rim_pkg.
module rim_coord
(
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [rim_pkg::COEF_W-1:0]   coef_a,
    input  logic signed [rim_pkg::COEF_W-1:0]   coef_b,
    input  logic signed [rim_pkg::DELTA_W-1:0]  delta_a,
    input  logic signed [rim_pkg::DELTA_W-1:0]  delta_b,
    input  logic                                sub_b,
    input  logic        [rim_pkg::COORD_W-1:0]  center,
    output logic signed [rim_pkg::POS_W-1:0]    pos
);

    logic signed [rim_pkg::PROD_W-1:0] prod_a_reg;
    logic signed [rim_pkg::PROD_W-1:0] prod_b_reg;
    logic signed [rim_pkg::PROD_W-1:0] prod_a_next;
    logic signed [rim_pkg::PROD_W-1:0] prod_b_next;
    logic signed [rim_pkg::SUM_W-1:0]  sum;
    logic signed [rim_pkg::SUM_W-1:0]  rounded;
    logic signed [rim_pkg::SUM_W-rim_pkg::FRAC_BITS-1:0] quot;

    assign prod_a_next = coef_a * delta_a;
    assign prod_b_next = coef_b * delta_b;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
    end

    // Adding one less than the scale before the floor shift gives the ceiling
    // for both signs of the sum.
    always_comb
    begin
        if (sub_b)
            sum = rim_pkg::SUM_W'(prod_a_reg) - rim_pkg::SUM_W'(prod_b_reg);
        else
            sum = rim_pkg::SUM_W'(prod_a_reg) + rim_pkg::SUM_W'(prod_b_reg);
        rounded = sum + rim_pkg::SUM_W'((1 << rim_pkg::FRAC_BITS) - 1);
        quot    = $signed(rounded[rim_pkg::SUM_W-1:rim_pkg::FRAC_BITS]);
        pos     = rim_pkg::POS_W'(quot) + rim_pkg::POS_W'($signed({1'b0, center}));
    end

endmodule

// File: design/rotation_inverse_mapper_unit.sv
// Top level of the rotation inverse mapper: configuration registers and the
// three-stage item pipeline, whose last stage is the output register. Depends on
// rim_pkg, rim_coord and rotation_inverse_mapper_unit_macros.svh.
//
// Usage: software writes the cosine and sine of the negated angle (signed Q1.14)
// and the source and destination sizes through cfg_we/cfg_addr/cfg_wdata while
// no item is in flight. Each destination pixel enters on s_axis as one item
// (tdata = dst_y:dst_x); the matching source pixel leaves on m_axis with
// tdata = src_y:src_x and tuser = inside flag. Outside points give 0, 0, 0.
// An accepted item passes through an input register, a product register fed by
// four 16x13 multipliers, and the output register. Throughput is one item per
// cycle while m_axis_tready is high; the multiplier stage sets the clock limit.
// Each stage has its own valid bit and advances whenever the stage after it is
// empty or moving, so a stalled receiver holds the output and backs the stages
// up one by one; s_axis_tready falls only once all three stages are full.
// Reset empties the pipeline and loads identity rotation and 4096 x 4096 sizes.
`include "rotation_inverse_mapper_unit_macros.svh"

module rotation_inverse_mapper_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [rim_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // dst_x, dst_y
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [rim_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // src_x, src_y
    output logic                               m_axis_tuser,   // inside_res
    input  logic                               cfg_we,
    input  logic [rim_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rim_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [rim_pkg::COEF_W-1:0]  cos_reg;
    logic [rim_pkg::COEF_W-1:0]  sin_reg;
    logic [rim_pkg::DIM_W-1:0]   src_w_reg;
    logic [rim_pkg::DIM_W-1:0]   src_h_reg;
    logic [rim_pkg::DIM_W-1:0]   dst_w_reg;
    logic [rim_pkg::DIM_W-1:0]   dst_h_reg;

    logic                          v1_reg;
    logic                          v2_reg;
    logic                          out_valid_reg;
    logic [rim_pkg::COORD_W-1:0]   x1_reg;
    logic [rim_pkg::COORD_W-1:0]   y1_reg;
    logic [rim_pkg::COORD_W-1:0]   src_x_reg;
    logic [rim_pkg::COORD_W-1:0]   src_y_reg;
    logic                          inside_reg;
    logic [rim_pkg::COORD_W-1:0]   src_x_next;
    logic [rim_pkg::COORD_W-1:0]   src_y_next;
    logic                          inside_next;

    logic ready1;
    logic ready2;
    logic ready3;

    logic signed [rim_pkg::DELTA_W-1:0] dx;
    logic signed [rim_pkg::DELTA_W-1:0] dy;
    logic signed [rim_pkg::POS_W-1:0]   sx;
    logic signed [rim_pkg::POS_W-1:0]   sy;
    logic        [rim_pkg::DIM_W-1:0]   lim_x;
    logic        [rim_pkg::DIM_W-1:0]   lim_y;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg   <= rim_pkg::COS_RESET;
            sin_reg   <= rim_pkg::SIN_RESET;
            src_w_reg <= rim_pkg::DIM_RESET;
            src_h_reg <= rim_pkg::DIM_RESET;
            dst_w_reg <= rim_pkg::DIM_RESET;
            dst_h_reg <= rim_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (rim_pkg::cfg_reg_t'(cfg_addr))
                rim_pkg::REG_COS:   cos_reg   <= cfg_wdata;
                rim_pkg::REG_SIN:   sin_reg   <= cfg_wdata;
                rim_pkg::REG_SRC_W: src_w_reg <= cfg_wdata[rim_pkg::DIM_W-1:0];
                rim_pkg::REG_SRC_H: src_h_reg <= cfg_wdata[rim_pkg::DIM_W-1:0];
                rim_pkg::REG_DST_W: dst_w_reg <= cfg_wdata[rim_pkg::DIM_W-1:0];
                rim_pkg::REG_DST_H: dst_h_reg <= cfg_wdata[rim_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign ready3        = !out_valid_reg || m_axis_tready;
    assign ready2        = !v2_reg || ready3;
    assign ready1        = !v1_reg || ready2;
    assign s_axis_tready = ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= s_axis_tvalid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && s_axis_tvalid)
        begin
            x1_reg <= s_axis_tdata[rim_pkg::COORD_W-1:0];
            y1_reg <= s_axis_tdata[2*rim_pkg::COORD_W-1:rim_pkg::COORD_W];
        end
        if (ready3 && v2_reg)
        begin
            src_x_reg  <= src_x_next;
            src_y_reg  <= src_y_next;
            inside_reg <= inside_next;
        end
    end

    // Offsets from the destination center, which is the size halved.
    assign dx = $signed({1'b0, x1_reg}) - $signed({1'b0, dst_w_reg[rim_pkg::DIM_W-1:1]});
    assign dy = $signed({1'b0, y1_reg}) - $signed({1'b0, dst_h_reg[rim_pkg::DIM_W-1:1]});

    rim_coord u_coord_x
    (
        .clk     (clk),
        .load    (ready2 && v1_reg),
        .coef_a  ($signed(cos_reg)),
        .coef_b  ($signed(sin_reg)),
        .delta_a (dx),
        .delta_b (dy),
        .sub_b   (1'b0),
        .center  (src_w_reg[rim_pkg::DIM_W-1:1]),
        .pos     (sx)
    );

    rim_coord u_coord_y
    (
        .clk     (clk),
        .load    (ready2 && v1_reg),
        .coef_a  ($signed(cos_reg)),
        .coef_b  ($signed(sin_reg)),
        .delta_a (dy),
        .delta_b (dx),
        .sub_b   (1'b1),
        .center  (src_h_reg[rim_pkg::DIM_W-1:1]),
        .pos     (sy)
    );

    // Source sizes above the largest image are clipped for the inside test.
    always_comb
    begin
        lim_x = (src_w_reg > rim_pkg::DIM_RESET) ? rim_pkg::DIM_RESET : src_w_reg;
        lim_y = (src_h_reg > rim_pkg::DIM_RESET) ? rim_pkg::DIM_RESET : src_h_reg;
        inside_next = !sx[rim_pkg::POS_W-1] && !sy[rim_pkg::POS_W-1]
            && (sx < $signed({{(rim_pkg::POS_W-rim_pkg::DIM_W){1'b0}}, lim_x}))
            && (sy < $signed({{(rim_pkg::POS_W-rim_pkg::DIM_W){1'b0}}, lim_y}));
        src_x_next = inside_next ? sx[rim_pkg::COORD_W-1:0] : '0;
        src_y_next = inside_next ? sy[rim_pkg::COORD_W-1:0] : '0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {src_y_reg, src_x_reg};
    assign m_axis_tuser  = inside_reg;

    `RIM_ASSERT_NOW(a_outside_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
    `RIM_ASSERT_NEXT(a_accept_fills, s_axis_tvalid && s_axis_tready, v1_reg)
    `RIM_ASSERT_NOW(a_empty_ready, !v1_reg, s_axis_tready)
    `RIM_ASSERT_NEXT(a_stage2_hold, v2_reg && !ready2, v2_reg)

endmodule
